>>> design/spg_pkg.sv
// shared types and constants of the spirograph point generator
package spg_pkg;

  localparam int ACC_W = 34;
  localparam int FRAC_W = 18;
  localparam int COLOR_BITS = 16;
  localparam int NUM_LOOKUPS = 6;

  localparam longint unsigned Q30_TWO_PI = 64'd6746518852;
  localparam longint unsigned Q30_PI = 64'd3373259426;
  localparam longint unsigned Q30_HALF_PI = 64'd1686629713;

  typedef enum logic [3:0] {
    CFG_CENTER_XY     = 4'd0,
    CFG_CAM_RADIUS    = 4'd1,
    CFG_RING_RADIUS   = 4'd2,
    CFG_WIGGLE_RADIUS = 4'd3,
    CFG_WIGGLE_STEP   = 4'd4,
    CFG_SPIN_STEP     = 4'd5,
    CFG_START_COLOR   = 4'd6,
    CFG_END_COLOR     = 4'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOOK,
    ST_DRAIN,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       take;
    logic       start_pt;
    logic       issue;
    logic [2:0] step;
    logic       advance;
    logic       div_start;
    logic       div_step;
    logic       color_apply;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } dp_flags_t;

endpackage

>>> design/spirograph_point_generator_core.sv
// top level of the spirograph point generator
// Each accepted frame index yields one pen point and color. After its input
// transfer it passes through a set-up step, six lookups issued one per cycle
// into the single sine rom and 16x16 multiplier, a wait until the three-stage
// lookup pipeline has drained, the bit-serial color dividers (three channels
// side by side), an update step and an output step that loads the output
// register. A new item is only taken in the idle state, once the last one is
// through. The next item is taken as soon as the result sits in the output
// register, even while it still waits for its transfer; the output step of
// that next item waits until the register has been freed.
module spirograph_point_generator_core #(
  parameter int LOOP_FRAMES = 5000,
  parameter int ANGLE_BITS = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [12:0]        frame_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pen_x,
  output logic signed [15:0] pen_y,
  output logic               move_only,
  output logic [7:0]         red_level,
  output logic [7:0]         green_level,
  output logic [7:0]         blue_level,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [47:0]        cfg_data
);

  spg_pkg::cmd_t cmd;
  spg_pkg::dp_flags_t status;

  assign cfg_ready = 1'b1;

  spg_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .cmd(cmd)
  );

  spg_datapath #(
    .LOOP_FRAMES(LOOP_FRAMES),
    .ANGLE_BITS(ANGLE_BITS),
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .status(status),
    .cfg_we(cfg_valid & cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .frame_index(frame_index),
    .pen_x(pen_x),
    .pen_y(pen_y),
    .move_only(move_only),
    .red_level(red_level),
    .green_level(green_level),
    .blue_level(blue_level)
  );

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared with no item in progress");

  a_pipe_idle_when_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !status.pipe_busy)
    else $error("lookup pipeline active while idle");

endmodule

>>> design/spg_ctrl.sv
// sequencer for one frame: set-up, table lookups, color division, result
module spg_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  spg_pkg::dp_flags_t status,
  output spg_pkg::cmd_t     cmd
);

  spg_pkg::state_t state, state_next;
  logic [4:0] cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spg_pkg::ST_IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    unique case (state)
      spg_pkg::ST_IDLE: begin
        if (in_valid) state_next = spg_pkg::ST_PREP;
        cnt_next = '0;
      end
      spg_pkg::ST_PREP: state_next = spg_pkg::ST_LOOK;
      spg_pkg::ST_LOOK: begin
        if (cnt == 5'(spg_pkg::NUM_LOOKUPS - 1)) begin
          state_next = spg_pkg::ST_DRAIN;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      spg_pkg::ST_DRAIN: begin
        if (!status.pipe_busy) state_next = spg_pkg::ST_DIV;
        cnt_next = '0;
      end
      spg_pkg::ST_DIV: begin
        if (cnt == 5'(spg_pkg::COLOR_BITS - 1)) begin
          state_next = spg_pkg::ST_APPLY;
          cnt_next = '0;
        end else begin
          cnt_next = cnt + 5'd1;
        end
      end
      spg_pkg::ST_APPLY: state_next = spg_pkg::ST_EMIT;
      spg_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) state_next = spg_pkg::ST_IDLE;
      end
      default: state_next = spg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      spg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      spg_pkg::ST_PREP: cmd.start_pt = 1'b1;
      spg_pkg::ST_LOOK: begin
        cmd.issue = 1'b1;
        cmd.step = cnt[2:0];
      end
      spg_pkg::ST_DRAIN: begin
        cmd.advance = !status.pipe_busy;
        cmd.div_start = !status.pipe_busy;
      end
      spg_pkg::ST_DIV: cmd.div_step = 1'b1;
      spg_pkg::ST_APPLY: cmd.color_apply = 1'b1;
      spg_pkg::ST_EMIT: cmd.emit = !out_valid || out_ready;
      default: cmd = '0;
    endcase
  end

endmodule

>>> design/spg_datapath.sv
// phases, sine rom, multiply-accumulate, color dividers and result registers
module spg_datapath #(
  parameter int LOOP_FRAMES = 5000,
  parameter int ANGLE_BITS = 16,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input  logic                 clk,
  input  logic                 rst,
  input  spg_pkg::cmd_t        cmd,
  output spg_pkg::dp_flags_t   status,
  input  logic                 cfg_we,
  input  logic [3:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic [12:0]          frame_index,
  output logic signed [15:0]   pen_x,
  output logic signed [15:0]   pen_y,
  output logic                 move_only,
  output logic [7:0]           red_level,
  output logic [7:0]           green_level,
  output logic [7:0]           blue_level
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH);
  localparam int PW = ANGLE_BITS + IW;
  localparam int DW = $clog2(LOOP_FRAMES + 1);
  localparam longint unsigned REV_STEP =
    ((64'd1 << ANGLE_BITS) * 64'd1000000000 + 64'd314159265359) / 64'd628318530718;
  localparam int CW = spg_pkg::COLOR_BITS;

  function automatic logic signed [15:0] sine_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    logic neg;
    x = k * spg_pkg::Q30_TWO_PI / SINE_TABLE_DEPTH;
    neg = 1'b0;
    if (x >= spg_pkg::Q30_PI) begin
      neg = 1'b1;
      x = x - spg_pkg::Q30_PI;
    end
    if (x > spg_pkg::Q30_HALF_PI) x = spg_pkg::Q30_PI - x;
    x2 = (x * x) >> 30;
    term = x;
    sum = x;
    // taylor terms up to x^15
    term = ((term * x2) >> 30) / 64'd6;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum = sum - term;
    sum = (sum + 64'd32768) >> 16;
    return neg ? -16'(sum) : 16'(sum);
  endfunction

  logic signed [15:0] rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic signed [15:0] ENTRY = sine_entry(longint'(k));
    assign rom[k] = ENTRY;
  end

  // configuration
  logic [31:0] center_xy;
  logic [14:0] cam_radius;
  logic [14:0] ring_radius;
  logic [14:0] wiggle_radius;
  logic [13:0] wiggle_step;
  logic signed [15:0] spin_step;
  logic [47:0] start_color;
  logic [47:0] end_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_xy <= '0;
      cam_radius <= '0;
      ring_radius <= '0;
      wiggle_radius <= '0;
      wiggle_step <= '0;
      spin_step <= '0;
      start_color <= '0;
      end_color <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spg_pkg::CFG_CENTER_XY:     center_xy <= cfg_data[31:0];
        spg_pkg::CFG_CAM_RADIUS:    cam_radius <= cfg_data[14:0];
        spg_pkg::CFG_RING_RADIUS:   ring_radius <= cfg_data[14:0];
        spg_pkg::CFG_WIGGLE_RADIUS: wiggle_radius <= cfg_data[14:0];
        spg_pkg::CFG_WIGGLE_STEP:   wiggle_step <= cfg_data[13:0];
        spg_pkg::CFG_SPIN_STEP:     spin_step <= cfg_data[15:0];
        spg_pkg::CFG_START_COLOR:   start_color <= cfg_data;
        spg_pkg::CFG_END_COLOR:     end_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // curve state
  logic [ANGLE_BITS-1:0] wiggle_phase;
  logic [ANGLE_BITS-1:0] revolution_phase;
  logic [ANGLE_BITS-1:0] spin_phase;
  logic [CW-1:0] color_now [3];
  logic first_point;
  logic [DW-1:0] div_q;
  logic [CW-1:0] quo [3];
  logic [DW:0] rem [3];
  logic dir [3];

  logic [13:0] frames_left;
  assign frames_left = 14'(LOOP_FRAMES) - {1'b0, frame_index};

  always_ff @(posedge clk) begin
    if (rst) begin
      wiggle_phase <= '0;
      revolution_phase <= '0;
      spin_phase <= '0;
      first_point <= 1'b1;
      for (int c = 0; c < 3; c++) color_now[c] <= '0;
    end else begin
      if (cmd.take && frame_index == 13'd0) begin
        wiggle_phase <= '0;
        revolution_phase <= '0;
        spin_phase <= '0;
        first_point <= 1'b1;
        for (int c = 0; c < 3; c++) color_now[c] <= start_color[16*c +: 16];
      end
      if (cmd.advance) begin
        revolution_phase <= revolution_phase + ANGLE_BITS'(REV_STEP);
        spin_phase <= spin_phase + ANGLE_BITS'(spin_step);
        wiggle_phase <= wiggle_phase + ANGLE_BITS'(wiggle_step);
      end
      if (cmd.color_apply) begin
        for (int c = 0; c < 3; c++) begin
          color_now[c] <= dir[c] ? color_now[c] + quo[c] : color_now[c] - quo[c];
        end
      end
      if (cmd.emit) first_point <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      if ({1'b0, frame_index} >= 14'(LOOP_FRAMES)) div_q <= DW'(1);
      else div_q <= DW'(frames_left);
    end
  end

  // bit-serial restoring dividers, one per channel
  logic [DW:0] trial [3];
  always_comb begin
    for (int c = 0; c < 3; c++) trial[c] = {rem[c][DW-1:0], quo[c][CW-1]};
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      if (cmd.div_start) begin
        dir[c] <= end_color[16*c +: 16] >= color_now[c];
        quo[c] <= (end_color[16*c +: 16] >= color_now[c]) ?
                  end_color[16*c +: 16] - color_now[c] :
                  color_now[c] - end_color[16*c +: 16];
        rem[c] <= '0;
      end else if (cmd.div_step) begin
        if (trial[c] >= {1'b0, div_q}) begin
          rem[c] <= trial[c] - {1'b0, div_q};
          quo[c] <= {quo[c][CW-2:0], 1'b1};
        end else begin
          rem[c] <= trial[c];
          quo[c] <= {quo[c][CW-2:0], 1'b0};
        end
      end
    end
  end

  // lookup and multiply-accumulate pipeline
  logic [ANGLE_BITS-1:0] phase_sel;
  logic [ANGLE_BITS-1:0] phase_adj;
  logic [PW-1:0] idx_prod;
  logic [IW-1:0] idx_q;
  logic v1, v2, v3;
  logic [2:0] tag1, tag2, tag3;
  logic signed [15:0] rom_q;
  logic [14:0] radius_sel;
  logic signed [31:0] prod_q;
  logic [spg_pkg::ACC_W-1:0] x_acc;
  logic [spg_pkg::ACC_W-1:0] y_acc;

  always_comb begin
    case (cmd.step[2:1])
      2'd0: phase_sel = wiggle_phase;
      2'd1: phase_sel = revolution_phase;
      default: phase_sel = spin_phase;
    endcase
    case (tag2[2:1])
      2'd0: radius_sel = wiggle_radius;
      2'd1: radius_sel = cam_radius;
      default: radius_sel = ring_radius;
    endcase
  end

  // even steps take cosine, a quarter turn ahead
  assign phase_adj = cmd.step[0] ? phase_sel :
                     phase_sel + ANGLE_BITS'(1 << (ANGLE_BITS - 2));
  assign idx_prod = PW'(phase_adj) * PW'(SINE_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    idx_q <= idx_prod[PW-1:ANGLE_BITS];
    tag1 <= cmd.step;
    rom_q <= rom[idx_q];
    tag2 <= tag1;
    prod_q <= $signed({1'b0, radius_sel}) * rom_q;
    tag3 <= tag2;
    if (cmd.start_pt) begin
      x_acc <= {center_xy[15:0], 18'd0} + spg_pkg::ACC_W'(1 << (spg_pkg::FRAC_W - 1));
      y_acc <= {center_xy[31:16], 18'd0} + spg_pkg::ACC_W'(1 << (spg_pkg::FRAC_W - 1));
    end else if (v3) begin
      if (tag3[0]) y_acc <= y_acc + spg_pkg::ACC_W'(prod_q);
      else x_acc <= x_acc + spg_pkg::ACC_W'(prod_q);
    end
  end

  assign status.pipe_busy = v1 | v2 | v3;

  // result registers
  logic [23:0] lvl [3];
  always_comb begin
    for (int c = 0; c < 3; c++) lvl[c] = 24'(color_now[c]) * 24'd255;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pen_x <= x_acc[spg_pkg::ACC_W-1:spg_pkg::FRAC_W];
      pen_y <= y_acc[spg_pkg::ACC_W-1:spg_pkg::FRAC_W];
      move_only <= first_point;
      red_level <= lvl[0][23:16];
      green_level <= lvl[1][23:16];
      blue_level <= lvl[2][23:16];
    end
  end

endmodule
